// ----- sv/mite_pkg.sv -----
package mite_pkg;

  localparam logic [5:0] OP_REGIMM = 6'h01;
  localparam logic [5:0] OP_BEQ    = 6'h04;
  localparam logic [5:0] OP_BNE    = 6'h05;
  localparam logic [5:0] OP_BLEZ   = 6'h06;
  localparam logic [5:0] OP_BGTZ   = 6'h07;
  localparam logic [5:0] OP_ADDI   = 6'h08;
  localparam logic [5:0] OP_ADDIU  = 6'h09;
  localparam logic [5:0] OP_SLTI   = 6'h0A;
  localparam logic [5:0] OP_SLTIU  = 6'h0B;
  localparam logic [5:0] OP_ANDI   = 6'h0C;
  localparam logic [5:0] OP_ORI    = 6'h0D;
  localparam logic [5:0] OP_XORI   = 6'h0E;
  localparam logic [5:0] OP_LUI    = 6'h0F;
  localparam logic [5:0] OP_LB     = 6'h20;
  localparam logic [5:0] OP_LH     = 6'h21;
  localparam logic [5:0] OP_LWL    = 6'h22;
  localparam logic [5:0] OP_LW     = 6'h23;
  localparam logic [5:0] OP_LBU    = 6'h24;
  localparam logic [5:0] OP_LHU    = 6'h25;
  localparam logic [5:0] OP_LWR    = 6'h26;
  localparam logic [5:0] OP_SB     = 6'h28;
  localparam logic [5:0] OP_SH     = 6'h29;
  localparam logic [5:0] OP_SW     = 6'h2B;

  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_ADDR  = 2'd1;
  localparam logic [1:0] FLT_OVF   = 2'd2;
  localparam logic [1:0] FLT_ILL   = 2'd3;

  localparam logic [31:0] DATA_BASE   = 32'h2000_0000;
  localparam logic [29:0] PORT_OUT_WD = 30'h0C00_0001;
  localparam logic [31:0] TEXT_LO     = 32'h1000_0000;
  localparam logic [31:0] TEXT_HI     = 32'h1100_0000;

  typedef struct packed {
    logic        we;
    logic [4:0]  dst;
    logic [31:0] val;
  } rf_wr_t;

endpackage

// ----- sv/mips_itype_execute.sv -----
// I-type execute unit: one 32-bit instruction per request on the slave stream,
// one result per instruction on the master stream, in order.
// s_axis_tdata_i carries the instruction word; m_axis_tdata_o carries next pc,
// fault code and output byte, m_axis_tuser_o flags a write to the output port.
// Pipeline: the register file is read at acceptance, stage 1 executes,
// checks addresses, updates the pc and accesses the byte-lane data memory, and
// stage 2 merges load data, writes the register file and loads the output
// register, which presents the result.
// One instruction is taken every cycle unless the pipeline holds or the memory
// clear runs; results of older instructions, loads included, are forwarded, so there is no interlock.
// Reset clears the pc to 0x10000000 and the register file valid bits, then
// zeroes the data memory one 32-bit word per cycle, all 2**(DATA_ADDR_BITS-2)
// words, during which s_axis_tready_o stays low.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready_o drops.
module mips_itype_execute #(
  parameter int DATA_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] instr
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] next_pc, [33:32] fault, [41:34] out_byte
  output logic        m_axis_tuser_o    // [0] out_valid
);

  localparam int WA = DATA_ADDR_BITS - 2;

  logic advance, accept;

  // reset clearing pass
  logic          clr_q, clr_d;
  logic [WA-1:0] clr_cnt_q, clr_cnt_d;

  // stage 1
  logic        s1_vld_q;
  logic [31:0] s1_ins_q;
  logic        s1_rsv_q, s1_rtv_q;
  logic [31:0] rf_rs_rd, rf_rt_rd;

  // stage 2
  logic        s2_vld_q, s2_ld_q, s2_we_q;
  logic [5:0]  s2_op_q;
  logic [1:0]  s2_o_q;
  logic [31:0] s2_b_q, s2_alu_q, s2_npc_q;
  logic [4:0]  s2_dst_q;
  logic [1:0]  s2_fault_q;
  logic        s2_ov_q;
  logic [7:0]  s2_ob_q;
  logic [31:0] s2_val;

  mite_pkg::rf_wr_t lw_q, s2_wr;

  logic [31:0] rf_vld_q;
  logic [31:0] pc_q;

  logic        out_vld_q;
  logic [31:0] out_pc_q;
  logic [1:0]  out_fault_q;
  logic        out_ov_q;
  logic [7:0]  out_ob_q;

  assign advance = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = advance && !clr_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // register file: two copies for the two read ports
  mite_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rs (
    .clk_i, .we_i(advance && s2_wr.we), .waddr_i(s2_wr.dst), .wdata_i(s2_wr.val),
    .re_i(s_axis_tready_o), .raddr_i(s_axis_tdata_i[25:21]), .rdata_o(rf_rs_rd)
  );
  mite_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rt (
    .clk_i, .we_i(advance && s2_wr.we), .waddr_i(s2_wr.dst), .wdata_i(s2_wr.val),
    .re_i(s_axis_tready_o), .raddr_i(s_axis_tdata_i[20:16]), .rdata_o(rf_rt_rd)
  );

  // stage 1 decode and execute
  logic [5:0]  op;
  logic [4:0]  rs, rt;
  logic [15:0] imm;
  logic [31:0] sx, a, b, ea, st, o, tgt;
  logic        win, not_last;
  logic [WA-1:0] word;
  logic [1:0]  boff;
  logic        wr, ld, link, taken, is_st, port;
  logic [1:0]  fault;
  logic [31:0] val, npc;
  logic [3:0]  lane_we;
  logic [7:0]  lane_wd [4];
  logic [WA-1:0] lane_wa [4], lane_ra [4];
  logic [7:0]  lane_rd [4];

  assign op  = s1_ins_q[31:26];
  assign rs  = s1_ins_q[25:21];
  assign rt  = s1_ins_q[20:16];
  assign imm = s1_ins_q[15:0];
  assign sx  = {{16{imm[15]}}, imm};

  always_comb begin
    a = rf_rs_rd & {32{s1_rsv_q}};
    if (s2_wr.we && s2_wr.dst == rs) begin
      a = s2_wr.val;
    end else if (lw_q.we && lw_q.dst == rs) begin
      a = lw_q.val;
    end
    b = rf_rt_rd & {32{s1_rtv_q}};
    if (s2_wr.we && s2_wr.dst == rt) begin
      b = s2_wr.val;
    end else if (lw_q.we && lw_q.dst == rt) begin
      b = lw_q.val;
    end
  end

  assign ea       = a + sx;
  assign st       = (op == mite_pkg::OP_LWL) ? ea - 32'd1 : ea;
  assign o        = st - mite_pkg::DATA_BASE;
  assign win      = (st >= mite_pkg::DATA_BASE) && (o[31:DATA_ADDR_BITS] == '0);
  assign not_last = o[DATA_ADDR_BITS-1:0] != '1;
  assign word     = o[DATA_ADDR_BITS-1:2];
  assign boff     = o[1:0];
  assign tgt      = pc_q + 32'd4 + {sx[29:0], 2'b00};
  assign port     = ea[31:2] == mite_pkg::PORT_OUT_WD;

  always_comb begin
    wr = 1'b0;
    ld = 1'b0;
    link = 1'b0;
    taken = 1'b0;
    is_st = 1'b0;
    fault = mite_pkg::FLT_NONE;
    val = '0;
    lane_we = '0;
    lane_wd[0] = b[7:0];
    lane_wd[1] = b[7:0];
    lane_wd[2] = b[7:0];
    lane_wd[3] = b[7:0];
    unique case (op)
      mite_pkg::OP_ADDIU: begin
        val = ea;
        wr = 1'b1;
      end
      mite_pkg::OP_ADDI: begin
        val = ea;
        if ((a[31] == sx[31]) && (ea[31] != a[31])) begin
          fault = mite_pkg::FLT_OVF;
        end else begin
          wr = 1'b1;
        end
      end
      mite_pkg::OP_ANDI: begin
        val = a & {16'd0, imm};
        wr = 1'b1;
      end
      mite_pkg::OP_ORI: begin
        val = a | {16'd0, imm};
        wr = 1'b1;
      end
      mite_pkg::OP_XORI: begin
        val = a ^ {16'd0, imm};
        wr = 1'b1;
      end
      mite_pkg::OP_SLTI: begin
        val = {31'd0, $signed(a) < $signed(sx)};
        wr = 1'b1;
      end
      mite_pkg::OP_SLTIU: begin
        val = {31'd0, a < sx};
        wr = 1'b1;
      end
      mite_pkg::OP_LUI: begin
        val = {imm, 16'd0};
        wr = 1'b1;
      end
      mite_pkg::OP_LB, mite_pkg::OP_LBU: begin
        ld = 1'b1;
        if (!win) fault = mite_pkg::FLT_ADDR;
      end
      mite_pkg::OP_LH, mite_pkg::OP_LHU: begin
        ld = 1'b1;
        if (ea[0] || !win || !not_last) fault = mite_pkg::FLT_ADDR;
      end
      mite_pkg::OP_LW: begin
        ld = 1'b1;
        if (ea[1:0] != 2'b00 || !win) fault = mite_pkg::FLT_ADDR;
      end
      mite_pkg::OP_LWL, mite_pkg::OP_LWR: begin
        ld = 1'b1;
        if (!win || !not_last) fault = mite_pkg::FLT_ADDR;
      end
      mite_pkg::OP_SB: begin
        is_st = 1'b1;
        if (!port) begin
          if (!win) fault = mite_pkg::FLT_ADDR;
          else lane_we[boff] = 1'b1;
        end
      end
      mite_pkg::OP_SH: begin
        is_st = 1'b1;
        if (ea[0]) begin
          fault = mite_pkg::FLT_ADDR;
        end else if (!port) begin
          if (!win) fault = mite_pkg::FLT_ADDR;
          else begin
            lane_we[boff] = 1'b1;
            lane_we[boff + 2'd1] = 1'b1;
            lane_wd[boff] = b[15:8];
          end
        end
      end
      mite_pkg::OP_SW: begin
        is_st = 1'b1;
        if (ea[1:0] != 2'b00) begin
          fault = mite_pkg::FLT_ADDR;
        end else if (!port) begin
          if (!win) fault = mite_pkg::FLT_ADDR;
          else begin
            lane_we = '1;
            lane_wd[0] = b[31:24];
            lane_wd[1] = b[23:16];
            lane_wd[2] = b[15:8];
          end
        end
      end
      mite_pkg::OP_BEQ:  taken = a == b;
      mite_pkg::OP_BNE:  taken = a != b;
      mite_pkg::OP_BLEZ: taken = (a == '0) || a[31];
      mite_pkg::OP_BGTZ: taken = !a[31] && (a != '0);
      mite_pkg::OP_REGIMM: begin
        unique case (rt)
          mite_pkg::RI_BLTZ:   taken = a[31];
          mite_pkg::RI_BGEZ:   taken = !a[31];
          mite_pkg::RI_BLTZAL: begin
            taken = a[31];
            link = 1'b1;
          end
          mite_pkg::RI_BGEZAL: begin
            taken = !a[31];
            link = 1'b1;
          end
          default: fault = mite_pkg::FLT_ILL;
        endcase
      end
      default: fault = mite_pkg::FLT_ILL;
    endcase
    if (taken && (tgt < mite_pkg::TEXT_LO || tgt > mite_pkg::TEXT_HI)) begin
      fault = mite_pkg::FLT_ADDR;
    end
    if (fault != mite_pkg::FLT_NONE) begin
      lane_we = '0;
    end
  end

  assign npc = (fault != mite_pkg::FLT_NONE) ? pc_q : (taken ? tgt : pc_q + 32'd4);

  // data memory: four byte lanes, lane k holds byte offsets 4n+k
  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign lane_ra[l] = (2'(l) >= boff) ? word : word + WA'(1);
    assign lane_wa[l] = clr_q ? clr_cnt_q : lane_ra[l];
    mite_ram #(.WIDTH(8), .DEPTH(2 ** WA)) u_dmem (
      .clk_i,
      .we_i(clr_q || (advance && s1_vld_q && lane_we[l])),
      .waddr_i(lane_wa[l]),
      .wdata_i(clr_q ? 8'd0 : lane_wd[l]),
      .re_i(advance),
      .raddr_i(lane_ra[l]),
      .rdata_o(lane_rd[l])
    );
  end

  // stage 2 load merge
  logic [7:0] m0, m1, m2, m3;
  assign m0 = lane_rd[s2_o_q];
  assign m1 = lane_rd[s2_o_q + 2'd1];
  assign m2 = lane_rd[s2_o_q + 2'd2];
  assign m3 = lane_rd[s2_o_q + 2'd3];

  always_comb begin
    s2_val = s2_alu_q;
    if (s2_ld_q) begin
      case (s2_op_q)
        mite_pkg::OP_LB:  s2_val = {{24{m0[7]}}, m0};
        mite_pkg::OP_LBU: s2_val = {24'd0, m0};
        mite_pkg::OP_LH:  s2_val = {{16{m0[7]}}, m0, m1};
        mite_pkg::OP_LHU: s2_val = {16'd0, m0, m1};
        mite_pkg::OP_LWL: s2_val = {m0, m1, s2_b_q[15:0]};
        mite_pkg::OP_LWR: s2_val = {s2_b_q[31:16], m0, m1};
        default:          s2_val = {m0, m1, m2, m3};
      endcase
    end
    s2_wr.we  = s2_vld_q && s2_we_q;
    s2_wr.dst = s2_dst_q;
    s2_wr.val = s2_val;
  end

  assign clr_d     = clr_q && (clr_cnt_q != '1);
  assign clr_cnt_d = clr_cnt_q + WA'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      lw_q      <= '0;
      rf_vld_q  <= '0;
      pc_q      <= mite_pkg::TEXT_LO;
    end else begin
      if (clr_q) begin
        clr_q     <= clr_d;
        clr_cnt_q <= clr_cnt_d;
      end
      if (advance) begin
        s1_vld_q  <= accept;
        s2_vld_q  <= s1_vld_q;
        out_vld_q <= s2_vld_q;
        lw_q      <= s2_wr;
        if (s2_wr.we) rf_vld_q[s2_wr.dst] <= 1'b1;
        if (s1_vld_q && fault == mite_pkg::FLT_NONE) pc_q <= npc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ins_q <= s_axis_tdata_i;
      s1_rsv_q <= rf_vld_q[s_axis_tdata_i[25:21]];
      s1_rtv_q <= rf_vld_q[s_axis_tdata_i[20:16]];
    end
    if (advance) begin
      s2_ld_q    <= ld && fault == mite_pkg::FLT_NONE;
      s2_op_q    <= op;
      s2_o_q     <= boff;
      s2_b_q     <= b;
      s2_alu_q   <= link ? pc_q + 32'd8 : val;
      s2_we_q    <= fault == mite_pkg::FLT_NONE && (link || (wr || ld) && rt != 5'd0);
      s2_dst_q   <= link ? 5'd31 : rt;
      s2_npc_q   <= npc;
      s2_fault_q <= fault;
      s2_ov_q    <= is_st && port && fault == mite_pkg::FLT_NONE;
      s2_ob_q    <= (is_st && port && fault == mite_pkg::FLT_NONE) ? b[7:0] : 8'd0;
      out_pc_q    <= s2_npc_q;
      out_fault_q <= s2_fault_q;
      out_ov_q    <= s2_ov_q;
      out_ob_q    <= s2_ob_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_ob_q, out_fault_q, out_pc_q};
  assign m_axis_tuser_o  = out_ov_q;

  a_rf_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_wr.we |-> s2_wr.dst != 5'd0)
    else $error("write to register zero");

  a_fault_no_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33:32] != mite_pkg::FLT_NONE |-> !m_axis_tuser_o)
    else $error("port write on faulting instruction");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_vld_q && !s2_vld_q)
    else $error("instruction in flight during memory clear");

endmodule

// ----- sv/mite_ram.sv -----
module mite_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
